// ===== design/first_fit_heap_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_defines.svh
// Assertion macros used by the allocator's sequencer (ffha_seq).
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ffha_pkg.sv =====
// ---------------------------------------------------------------------------
// ffha_pkg
// Types, codes and constants of the first-fit heap allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int unsigned DefArenaBytes = 65536;
  localparam int unsigned DefMaxFree    = 64;
  localparam int unsigned DefMaxUsed    = 64;

  localparam logic [15:0] HdrBytes = 16'd32;
  localparam logic [15:0] SplitMin = 16'd48;

  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_FREED   = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic        action;
    logic [19:0] request_bytes;
    logic [15:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_offset;
    logic [15:0] granted_bytes;
  } res_t;

  // One table entry: header offset and payload size.
  typedef struct packed {
    logic [15:0] hdr;
    logic [15:0] size;
  } ext_t;

endpackage

`default_nettype wire

// ===== design/ffha_ram.sv =====
// ---------------------------------------------------------------------------
// ffha_ram
// Extent table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ffha_ram
  import ffha_pkg::*;
#(
  parameter int unsigned Depth = DefMaxFree,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire ext_t             wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output ext_t                  rdata_o
);

  ext_t mem_q [Depth];
  ext_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/ffha_seq.sv =====
// ---------------------------------------------------------------------------
// ffha_seq
// Sequencer: scans and shifts the free and used tables one entry a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_defines.svh"

module ffha_seq
  import ffha_pkg::*;
#(
  parameter int unsigned ARENA_BYTES = DefArenaBytes,
  parameter int unsigned MAX_FREE    = DefMaxFree,
  parameter int unsigned MAX_USED    = DefMaxUsed
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam int unsigned FAW = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
  localparam int unsigned UAW = (MAX_USED > 1) ? $clog2(MAX_USED) : 1;
  localparam int unsigned FCW = $clog2(MAX_FREE + 1);
  localparam int unsigned UCW = $clog2(MAX_USED + 1);
  localparam int unsigned CW  = (FCW > UCW) ? FCW : UCW;
  localparam logic [15:0] InitSize = 16'(((ARENA_BYTES - 32) / 16) * 16);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_ASCAN  = 4'd3;
  localparam logic [3:0] S_FUSCAN = 4'd4;
  localparam logic [3:0] S_FPSCAN = 4'd5;
  localparam logic [3:0] S_FDEC   = 4'd6;
  localparam logic [3:0] S_USHL   = 4'd7;
  localparam logic [3:0] S_FSHL   = 4'd8;
  localparam logic [3:0] S_FSHR   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]     state_q, state_d;
  logic           act_q, act_d;
  logic [20:0]    need_q, need_d;
  logic [15:0]    off_q, off_d;
  logic [FCW-1:0] fcnt_q, fcnt_d;
  logic [UCW-1:0] ucnt_q, ucnt_d;
  logic [CW-1:0]  idx_q, idx_d, lim_q, lim_d, pidx_q, pidx_d;
  logic [CW-1:0]  uix_q, uix_d, pos_q, pos_d;
  logic           pend_q, pend_d, down_q, down_d;
  ext_t           blk_q, blk_d, prev_q, prev_d, next_q, next_d;
  logic           nok_q, nok_d, mn_q, mn_d, mp_q, mp_d;
  logic [2:0]     st_q, st_d;
  logic [15:0]    roff_q, roff_d, rbytes_q, rbytes_d;

  logic           issue;
  logic [CW-1:0]  raddr;
  logic           fwe, uwe;
  logic [FAW-1:0] fwa;
  logic [UAW-1:0] uwa;
  ext_t           fwd, uwd, fdat, udat;
  logic [15:0]    rem;
  logic           mn_c, mp_c;

  ffha_ram #(.Depth(MAX_FREE), .AddrW(FAW)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (fwa),
    .wdata_i (fwd),
    .raddr_i (raddr[FAW-1:0]),
    .rdata_o (fdat)
  );

  ffha_ram #(.Depth(MAX_USED), .AddrW(UAW)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (uwe),
    .waddr_i (uwa),
    .wdata_i (uwd),
    .raddr_i (raddr[UAW-1:0]),
    .rdata_o (udat)
  );

  // Read pointer walks up to lim_q, or down to it for the right shift.
  assign issue = down_q ? (idx_q > lim_q) : (idx_q < lim_q);
  assign raddr = down_q ? (idx_q - CW'(1)) : idx_q;
  assign rem   = fdat.size - need_q[15:0];

  assign mn_c = nok_q &&
                ({1'b0, blk_q.hdr} + {1'b0, HdrBytes} + {1'b0, blk_q.size} ==
                 {1'b0, next_q.hdr});
  assign mp_c = (pos_q != '0) &&
                ({1'b0, prev_q.hdr} + {1'b0, HdrBytes} + {1'b0, prev_q.size} ==
                 {1'b0, blk_q.hdr});

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{status: st_q, granted_offset: roff_q, granted_bytes: rbytes_q};

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    need_d   = need_q;
    off_d    = off_q;
    fcnt_d   = fcnt_q;
    ucnt_d   = ucnt_q;
    idx_d    = idx_q;
    lim_d    = lim_q;
    pidx_d   = pidx_q;
    uix_d    = uix_q;
    pos_d    = pos_q;
    down_d   = down_q;
    blk_d    = blk_q;
    prev_d   = prev_q;
    next_d   = next_q;
    nok_d    = nok_q;
    mn_d     = mn_q;
    mp_d     = mp_q;
    st_d     = st_q;
    roff_d   = roff_q;
    rbytes_d = rbytes_q;
    pend_d   = 1'b0;
    fwe      = 1'b0;
    fwa      = '0;
    fwd      = '0;
    uwe      = 1'b0;
    uwa      = '0;
    uwd      = '0;

    // Scan and shift states advance the read pointer by default.
    if (state_q == S_ASCAN || state_q == S_FUSCAN || state_q == S_FPSCAN ||
        state_q == S_USHL || state_q == S_FSHL || state_q == S_FSHR) begin
      if (issue) begin
        idx_d  = down_q ? (idx_q - CW'(1)) : (idx_q + CW'(1));
        pend_d = 1'b1;
        pidx_d = raddr;
      end
    end

    unique case (state_q)
      S_INIT: begin
        fwe     = 1'b1;
        fwd     = '{hdr: 16'd0, size: InitSize};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          act_d   = req_i.action;
          need_d  = (21'(req_i.request_bytes) + 21'd15) & ~21'd15;
          off_d   = req_i.payload_offset;
          roff_d  = '0;
          rbytes_d = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        idx_d  = '0;
        down_d = 1'b0;
        if (!act_q) begin
          lim_d = CW'(fcnt_q);
          if (need_q == '0) begin
            st_d    = ST_ZERO;
            state_d = S_DONE;
          end else begin
            state_d = S_ASCAN;
          end
        end else begin
          lim_d = CW'(ucnt_q);
          if (off_q[3:0] != 4'd0 || off_q < HdrBytes) begin
            st_d    = ST_INVALID;
            state_d = S_DONE;
          end else begin
            state_d = S_FUSCAN;
          end
        end
      end
      S_ASCAN: begin
        if (pend_q && {5'd0, fdat.size} >= need_q) begin
          pend_d = 1'b0;
          if (ucnt_q >= UCW'(MAX_USED)) begin
            st_d    = ST_FULL;
            state_d = S_DONE;
          end else begin
            uwe    = 1'b1;
            uwa    = ucnt_q[UAW-1:0];
            ucnt_d = ucnt_q + UCW'(1);
            st_d   = ST_ALLOC;
            roff_d = fdat.hdr + HdrBytes;
            if (rem >= SplitMin) begin
              uwd      = '{hdr: fdat.hdr, size: need_q[15:0]};
              rbytes_d = need_q[15:0];
              fwe      = 1'b1;
              fwa      = pidx_q[FAW-1:0];
              fwd      = '{hdr: fdat.hdr + HdrBytes + need_q[15:0], size: rem - HdrBytes};
              state_d  = S_DONE;
            end else begin
              // Whole extent granted: close the gap in the free table.
              uwd      = fdat;
              rbytes_d = fdat.size;
              fcnt_d   = fcnt_q - FCW'(1);
              idx_d    = pidx_q + CW'(1);
              lim_d    = CW'(fcnt_q);
              state_d  = S_FSHL;
            end
          end
        end else if (!pend_q && !issue) begin
          st_d    = ST_NOFIT;
          state_d = S_DONE;
        end
      end
      S_FUSCAN: begin
        if (pend_q && udat.hdr == off_q - HdrBytes) begin
          pend_d  = 1'b0;
          blk_d   = udat;
          uix_d   = pidx_q;
          idx_d   = '0;
          lim_d   = CW'(fcnt_q);
          state_d = S_FPSCAN;
        end else if (!pend_q && !issue) begin
          st_d    = ST_INVALID;
          state_d = S_DONE;
        end
      end
      S_FPSCAN: begin
        if (pend_q) begin
          if (fdat.hdr >= blk_q.hdr) begin
            pend_d  = 1'b0;
            pos_d   = pidx_q;
            next_d  = fdat;
            nok_d   = 1'b1;
            state_d = S_FDEC;
          end else begin
            prev_d = fdat;
          end
        end else if (!issue) begin
          pos_d   = lim_q;
          nok_d   = 1'b0;
          state_d = S_FDEC;
        end
      end
      S_FDEC: begin
        mn_d = mn_c;
        mp_d = mp_c;
        if (!mn_c && !mp_c && fcnt_q >= FCW'(MAX_FREE)) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          st_d    = ST_FREED;
          ucnt_d  = ucnt_q - UCW'(1);
          idx_d   = uix_q + CW'(1);
          lim_d   = CW'(ucnt_q);
          down_d  = 1'b0;
          state_d = S_USHL;
        end
      end
      S_USHL: begin
        if (pend_q) begin
          uwe = 1'b1;
          uwa = UAW'(pidx_q - CW'(1));
          uwd = udat;
        end else if (!issue) begin
          priority if (mn_q && mp_q) begin
            fwe     = 1'b1;
            fwa     = FAW'(pos_q - CW'(1));
            fwd     = '{hdr: prev_q.hdr,
                        size: prev_q.size + HdrBytes + blk_q.size + HdrBytes + next_q.size};
            fcnt_d  = fcnt_q - FCW'(1);
            idx_d   = pos_q + CW'(1);
            lim_d   = CW'(fcnt_q);
            state_d = S_FSHL;
          end else if (mn_q) begin
            fwe     = 1'b1;
            fwa     = pos_q[FAW-1:0];
            fwd     = '{hdr: blk_q.hdr, size: blk_q.size + HdrBytes + next_q.size};
            state_d = S_DONE;
          end else if (mp_q) begin
            fwe     = 1'b1;
            fwa     = FAW'(pos_q - CW'(1));
            fwd     = '{hdr: prev_q.hdr, size: prev_q.size + HdrBytes + blk_q.size};
            state_d = S_DONE;
          end else begin
            // Open a slot at pos: move the tail up one, top entry first.
            fcnt_d  = fcnt_q + FCW'(1);
            idx_d   = CW'(fcnt_q);
            lim_d   = pos_q;
            down_d  = 1'b1;
            state_d = S_FSHR;
          end
        end
      end
      S_FSHL: begin
        // Reads run one entry ahead of writes, so addresses never meet.
        if (pend_q) begin
          fwe = 1'b1;
          fwa = FAW'(pidx_q - CW'(1));
          fwd = fdat;
        end else if (!issue) begin
          state_d = S_DONE;
        end
      end
      S_FSHR: begin
        if (pend_q) begin
          fwe = 1'b1;
          fwa = FAW'(pidx_q + CW'(1));
          fwd = fdat;
        end else if (!issue) begin
          fwe     = 1'b1;
          fwa     = pos_q[FAW-1:0];
          fwd     = blk_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      fcnt_q  <= FCW'(1);
      ucnt_q  <= '0;
      pend_q  <= 1'b0;
      down_q  <= 1'b0;
      idx_q   <= '0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      fcnt_q  <= fcnt_d;
      ucnt_q  <= ucnt_d;
      pend_q  <= pend_d;
      down_q  <= down_d;
      idx_q   <= idx_d;
      lim_q   <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    need_q   <= need_d;
    off_q    <= off_d;
    pidx_q   <= pidx_d;
    uix_q    <= uix_d;
    pos_q    <= pos_d;
    blk_q    <= blk_d;
    prev_q   <= prev_d;
    next_q   <= next_d;
    nok_q    <= nok_d;
    mn_q     <= mn_d;
    mp_q     <= mp_d;
    st_q     <= st_d;
    roff_q   <= roff_d;
    rbytes_q <= rbytes_d;
  end

  `FFHA_ASSERT_IMP(a_fcnt_max, 1'b1, fcnt_q <= FCW'(MAX_FREE), "free count overflow")
  `FFHA_ASSERT_IMP(a_ucnt_max, 1'b1, ucnt_q <= UCW'(MAX_USED), "used count overflow")
  `FFHA_ASSERT_IMP(a_grant_ok, state_q == S_DONE && st_q == ST_ALLOC,
                   rbytes_q != 16'd0 && roff_q[3:0] == 4'd0 && roff_q >= HdrBytes,
                   "bad grant")
  `FFHA_ASSERT_NXT(a_init, state_q == S_INIT, state_q == S_IDLE && fcnt_q == FCW'(1),
                   "init step")

endmodule

`default_nettype wire

// ===== design/first_fit_heap_allocator.sv =====
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a fixed arena with an address-sorted free table.
// ---------------------------------------------------------------------------
// One item is worked on at a time. The free and used tables each sit in a
// synchronous RAM with one read and one write port, and every scan or shift
// walks one entry per cycle. An allocate scans the free entries up to the
// first fit and, when the whole extent is granted, shifts the free extents
// above it down by one. A free scans the used entries for the block and the
// free entries for its place, shifts the used entries above the block down
// and, when no neighbour merges, shifts the free entries above the insertion
// point up. After reset, the init state sets up the initial extent
// before the first item is taken. The result waits in an output
// register, so the next item can be accepted while it is held.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned ARENA_BYTES = DefArenaBytes,
  parameter int unsigned MAX_FREE    = DefMaxFree,
  parameter int unsigned MAX_USED    = DefMaxUsed
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  logic seq_ready, res_valid, res_ready;
  res_t res;
  logic out_valid_q;
  res_t out_data_q;

  ffha_seq #(
    .ARENA_BYTES (ARENA_BYTES),
    .MAX_FREE    (MAX_FREE),
    .MAX_USED    (MAX_USED)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (seq_ready),
    .req_i       (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Load the output register when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign in_ready_o  = seq_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
